[hw/rtl/pts_pkg.sv]
`default_nettype none

package pts_pkg;

    localparam int WORD_W    = 48;
    localparam int FRAC_BITS = 16;
    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int HALF_W    = WORD_W / 2;
    localparam int PROD_W    = 2 * WORD_W;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_LOAD,
        S_TOP,
        S_TOP_CAP,
        S_MUL,
        S_SAT,
        S_ADD,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic             wr_en;
        logic             wr_from_in;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] rd_addr;
        logic             mop_load;
        logic             mul_en;
        logic [1:0]       phase;
        logic             sat_en;
        logic             add_en;
        logic             out_load;
        logic             out_last;
        logic [IDX_W-1:0] out_index;
        logic             ovf_clear;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
        mag = v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/polynomial_taylor_shift.sv]
// Loading: one coefficient item per cycle. After the last item of degree n,
// the shift runs n(n+1)/2 multiply-adds (four 24x24 partial products on one
// multiplier, saturate, add), each outer pass opening with a top read.
// Results then leave in turn (read, then load), held while the output stalls.
// Sync active-low reset: idle, empty load, shift point 0, overflow flag clear.
`default_nettype none

module polynomial_taylor_shift
    import pts_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_shift_point_we,
    input  wire logic signed [WORD_W-1:0] i_shift_point,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [WORD_W-1:0] i_coef_in,
    input  wire logic                     i_last_coef,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [WORD_W-1:0]      o_out_coef,
    output logic [IDX_W-1:0]              o_out_index,
    output logic                          o_out_last,
    output logic                          o_out_overflow
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_coef (i_last_coef),
        .o_in_stall  (o_in_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pts_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_shift_point_we (i_shift_point_we),
        .i_shift_point    (i_shift_point),
        .i_coef_in        (i_coef_in),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_coef       (o_out_coef),
        .o_out_index      (o_out_index),
        .o_out_last       (o_out_last),
        .o_out_overflow   (o_out_overflow)
    );

endmodule

`default_nettype wire

[hw/rtl/pts_dp.sv]
`default_nettype none

module pts_dp
    import pts_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_shift_point_we,
    input  wire logic signed [WORD_W-1:0] i_shift_point,
    input  wire logic signed [WORD_W-1:0] i_coef_in,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output logic signed [WORD_W-1:0]      o_out_coef,
    output logic [IDX_W-1:0]              o_out_index,
    output logic                          o_out_last,
    output logic                          o_out_overflow
);

    logic signed [WORD_W-1:0] r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rd_data;
    logic signed [WORD_W-1:0] r_shift_point;
    logic [WORD_W-1:0]        r_mag_a;
    logic [WORD_W-1:0]        r_mag_b;
    logic                     r_neg_b;
    logic [PROD_W-1:0]        r_acc;
    logic signed [WORD_W-1:0] r_prod;
    logic                     r_ovf;
    logic                     r_out_valid;

    logic                     neg;
    logic [HALF_W-1:0]        a_sel;
    logic [HALF_W-1:0]        b_sel;
    logic [WORD_W-1:0]        pp;
    logic [PROD_W-1:0]        pp_sh;
    logic [PROD_W-1:0]        q;
    logic                     mul_ovf;
    logic [WORD_W-1:0]        lim;
    logic signed [WORD_W-1:0] n_prod;
    logic [WORD_W:0]          sum_x;
    logic                     add_ovf;
    logic signed [WORD_W-1:0] sum;
    logic signed [WORD_W-1:0] wr_data;

    assign neg   = r_shift_point[WORD_W-1] ^ r_neg_b;
    assign a_sel = i_cmd.phase[0] ? r_mag_a[WORD_W-1:HALF_W] : r_mag_a[HALF_W-1:0];
    assign b_sel = i_cmd.phase[1] ? r_mag_b[WORD_W-1:HALF_W] : r_mag_b[HALF_W-1:0];
    assign pp    = WORD_W'(a_sel) * WORD_W'(b_sel);

    always_comb begin
        case (i_cmd.phase)
            2'd0:    pp_sh = PROD_W'(pp);
            2'd3:    pp_sh = PROD_W'(pp) << (2 * HALF_W);
            default: pp_sh = PROD_W'(pp) << HALF_W;
        endcase
    end

    // truncate the magnitude, then saturate against the signed range
    always_comb begin
        q       = r_acc >> FRAC_BITS;
        lim     = neg ? WORD_MIN : WORD_MAX;
        mul_ovf = (|q[PROD_W-1:WORD_W]) || (q[WORD_W-1:0] > lim);
        if (mul_ovf) begin
            n_prod = neg ? WORD_MIN : WORD_MAX;
        end else begin
            n_prod = neg ? (~q[WORD_W-1:0] + 1'b1) : q[WORD_W-1:0];
        end
    end

    always_comb begin
        sum_x   = {r_rd_data[WORD_W-1], r_rd_data} + {r_prod[WORD_W-1], r_prod};
        add_ovf = sum_x[WORD_W] != sum_x[WORD_W-1];
        if (add_ovf) begin
            sum = sum_x[WORD_W] ? WORD_MIN : WORD_MAX;
        end else begin
            sum = sum_x[WORD_W-1:0];
        end
    end

    assign wr_data = i_cmd.wr_from_in ? i_coef_in : sum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_mag_a <= mag(r_shift_point);
        if (i_cmd.mop_load) begin
            r_mag_b <= mag(r_rd_data);
            r_neg_b <= r_rd_data[WORD_W-1];
        end else if (i_cmd.add_en) begin
            r_mag_b <= mag(sum);
            r_neg_b <= sum[WORD_W-1];
        end
        if (i_cmd.mul_en) begin
            r_acc <= (i_cmd.phase == 2'd0) ? pp_sh : r_acc + pp_sh;
        end
        if (i_cmd.sat_en) begin
            r_prod <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_point <= '0;
            r_ovf         <= 1'b0;
        end else begin
            if (i_shift_point_we) begin
                r_shift_point <= i_shift_point;
            end
            if (i_cmd.ovf_clear) begin
                r_ovf <= 1'b0;
            end else if ((i_cmd.sat_en && mul_ovf) || (i_cmd.add_en && add_ovf)) begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_coef     <= r_rd_data;
            o_out_index    <= i_cmd.out_index;
            o_out_last     <= i_cmd.out_last;
            o_out_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/pts_ctrl.sv]
`default_nettype none

module pts_ctrl
    import pts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_last_coef,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_j, n_j;
    logic [1:0]       r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] j_dn;

    assign j_dn = r_j - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_phase <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_k     <= n_k;
            r_j     <= n_j;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_k        = r_k;
        n_j        = r_j;
        n_phase    = r_phase;
        n_idx      = r_idx;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        o_cmd.wr_addr = j_dn;
        o_cmd.rd_addr = j_dn;
        o_cmd.phase   = r_phase;

        case (r_state)
            S_LOAD: begin
                o_in_stall       = 1'b0;
                o_cmd.wr_addr    = r_cnt;
                o_cmd.wr_from_in = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_en = 1'b1;
                    // a full store closes the load as if last were set
                    if (i_last_coef || r_cnt == IDX_W'(DEPTH - 1)) begin
                        n_n   = r_cnt;
                        n_cnt = '0;
                        n_k   = '0;
                        n_j   = r_cnt;
                        n_idx = '0;
                        n_state = (r_cnt == '0) ? S_OUT_RD : S_TOP;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_TOP: begin
                o_cmd.rd_addr = r_n;
                n_state = S_TOP_CAP;
            end
            S_TOP_CAP: begin
                o_cmd.rd_addr  = r_n;
                o_cmd.mop_load = 1'b1;
                n_phase = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_phase == 2'd3) begin
                    n_state = S_SAT;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            S_SAT: begin
                o_cmd.sat_en = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_en = 1'b1;
                o_cmd.wr_en  = 1'b1;
                n_phase = '0;
                if (j_dn == r_k) begin
                    if (r_k + 1'b1 == r_n) begin
                        n_idx   = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_j     = r_n;
                        n_state = S_TOP;
                    end
                end else begin
                    n_j     = j_dn;
                    n_state = S_MUL;
                end
            end
            S_OUT_RD: begin
                o_cmd.rd_addr = r_idx;
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.rd_addr   = r_idx;
                o_cmd.out_index = r_idx;
                o_cmd.out_last  = (r_idx == r_n);
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_idx == r_n) begin
                        o_cmd.ovf_clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire
